FILE: sv/vabd_pkg.sv
// ----------------------------------------------------------------------------
// vabd_pkg: shared definitions for the voltmeter average and BCD display
// Request codes, fixed widths, reciprocal constants and the digit helpers.
// ----------------------------------------------------------------------------
package vabd_pkg;

	// Request codes carried in req_type. The fourth code is unused.
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_TEMP   = 2'd2
	} req_kind_t;

	// Samples averaged per group, 1 to 16.
	localparam int SAMPLES = 8;

	localparam int SAMPLE_W = 10;
	localparam int TEMP_W   = 8;
	localparam int ACC_W    = 14;
	localparam int CNT_W    = 4;
	localparam int VOLT_W   = 6;

	// Exact floor division of the group sum by SAMPLES: multiply and shift.
	localparam int AVG_SHIFT = 19;
	localparam int AVG_RECIP = (2 ** AVG_SHIFT + SAMPLES - 1) / SAMPLES;
	localparam int RECIP_W   = 20;

	// Scaling to tenths of a volt: (avg * 33 + 511) / 1023.
	localparam int SCALE_W     = 16;
	localparam int SCALE_ROUND = 511;
	localparam int DIV_SHIFT   = 26;
	localparam int DIV_RECIP   = (2 ** DIV_SHIFT + 1023 - 1) / 1023;
	localparam int DIV_RECIP_W = 17;

	// What one refresh tick drives onto the display.
	typedef struct packed {
		logic       sel;
		logic [6:0] segments;
		logic       point;
	} digit_t;

	// Splits a byte into two BCD nibbles: (val / 10) & 15 high, val % 10 low.
	function automatic logic [7:0] to_digits(input logic [7:0] val);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [7:0]  rem;
		prod = 16'(val) * 16'd205;
		quo  = prod[15:11];
		rem  = val - {quo, 3'b000} - {2'b00, quo, 1'b0};
		return {quo[3:0], rem[3:0]};
	endfunction

	// Seven-segment pattern gfedcba for a hex nibble.
	function automatic logic [6:0] seg7(input logic [3:0] nib);
		logic [6:0] pat;
		unique case (nib)
			4'h0: pat = 7'h3F;
			4'h1: pat = 7'h06;
			4'h2: pat = 7'h5B;
			4'h3: pat = 7'h4F;
			4'h4: pat = 7'h66;
			4'h5: pat = 7'h6D;
			4'h6: pat = 7'h7D;
			4'h7: pat = 7'h07;
			4'h8: pat = 7'h7F;
			4'h9: pat = 7'h67;
			4'hA: pat = 7'h77;
			4'hB: pat = 7'h7C;
			4'hC: pat = 7'h39;
			4'hD: pat = 7'h5E;
			4'hE: pat = 7'h79;
			4'hF: pat = 7'h71;
		endcase
		return pat;
	endfunction

endpackage

FILE: sv/vabd_req_if.sv
// ----------------------------------------------------------------------------
// vabd_req_if: request channel
// Valid/ready channel carrying samples, refresh ticks and temperature updates.
// ----------------------------------------------------------------------------
interface vabd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [9:0] sample_value;
	logic [7:0] temperature_value;
	logic       show_temperature;

	modport source (
		output valid, req_type, sample_value, temperature_value, show_temperature,
		input  ready
	);
	modport sink (
		input  valid, req_type, sample_value, temperature_value, show_temperature,
		output ready
	);
endinterface

FILE: sv/vabd_res_if.sv
// ----------------------------------------------------------------------------
// vabd_res_if: display result channel
// Valid/ready channel carrying one driven digit per refresh tick.
// ----------------------------------------------------------------------------
interface vabd_res_if;
	logic       valid;
	logic       ready;
	logic       digit_select;
	logic [6:0] segments;
	logic       decimal_point;
	logic [7:0] voltage_bcd;

	modport source (
		output valid, digit_select, segments, decimal_point, voltage_bcd,
		input  ready
	);
	modport sink (
		input  valid, digit_select, segments, decimal_point, voltage_bcd,
		output ready
	);
endinterface

FILE: sv/voltmeter_average_bcd_display.sv
// ----------------------------------------------------------------------------
// voltmeter_average_bcd_display: averaging voltmeter with two-digit display
// Averages converter samples, scales them to tenths of a volt in BCD and
// multiplexes voltage or temperature onto a two-digit seven-segment display.
// ----------------------------------------------------------------------------
//
// Channel  Modport  Role
// -------  -------  ---------------------------------------------------------
// req      sink     samples, refresh ticks and temperature updates
// res      source   one digit (select, segments, point, voltage) per tick
//
// One transaction is accepted per cycle when nothing downstream is stalled.
// A tick taken by the input register passes through the accumulation,
// averaging and scaling stages in that order, then the display stage loads
// the output register.
// A stalled result holds a tick in the display stage and everything behind it.
// Reset clears the sum, count, stored digits and the digit toggle at once.
//
module voltmeter_average_bcd_display (
	input  logic          clk,
	input  logic          arst_n,
	vabd_req_if.sink      req,
	vabd_res_if.source    res
);

	// Item attributes that travel with every stage of the pipeline.
	typedef struct packed {
		logic [1:0] kind;
		logic       show;
		logic [7:0] temp;
		logic       done;
	} item_t;

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	logic                           valid_s1;
	logic [1:0]                     kind_s1;
	logic [vabd_pkg::SAMPLE_W-1:0]  sample_s1;
	logic [vabd_pkg::TEMP_W-1:0]    temp_s1;
	logic                           show_s1;

	// Stage registers further down.
	logic                           valid_s2, valid_s3, valid_s4;
	item_t                          item_s2, item_s3, item_s4;
	logic [vabd_pkg::ACC_W-1:0]     sum_s2;
	logic [vabd_pkg::SAMPLE_W-1:0]  avg_s3;
	logic [vabd_pkg::VOLT_W-1:0]    volt_s4;

	// Architectural state.
	logic [vabd_pkg::ACC_W-1:0]     acc_q;
	logic [vabd_pkg::CNT_W-1:0]     cnt_q;
	logic [7:0]                     volt_digits_q;
	logic [7:0]                     temp_store_q;
	logic                           high_next_q;

	// Output register.
	logic                           res_valid_q;
	logic                           res_sel_q;
	logic [6:0]                     res_seg_q;
	logic                           res_point_q;
	logic [7:0]                     res_volt_q;

	// ------------------------------------------------------------------
	// Flow control. The display stage retires a tick only when the output
	// register is free or being emptied; any other item retires at once.
	// Each earlier stage moves on when the one after it is empty or moving.
	// ------------------------------------------------------------------
	logic tick_s4;
	logic go4, go3, go2, go1;
	logic free4, free3, free2, free1;

	assign tick_s4 = (item_s4.kind == vabd_pkg::REQ_TICK);
	assign go4     = valid_s4 & (~tick_s4 | ~res_valid_q | res.ready);
	assign free4   = ~valid_s4 | go4;
	assign go3     = valid_s3 & free4;
	assign free3   = ~valid_s3 | go3;
	assign go2     = valid_s2 & free3;
	assign free2   = ~valid_s2 | go2;
	assign go1     = valid_s1 & free2;
	assign free1   = ~valid_s1 | go1;

	assign req.ready = free1;

	logic req_take;
	assign req_take = req.valid & free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_s1   <= req.req_type;
			sample_s1 <= req.sample_value;
			temp_s1   <= req.temperature_value;
			show_s1   <= req.show_temperature;
		end
	end

	// ------------------------------------------------------------------
	// Accumulation, done as the item leaves stage 1. When a group fills
	// up the whole sum goes down the pipeline and the running sum and the
	// count start again from zero. A count that wraps to zero also closes
	// a group, which only happens with sixteen samples to a group.
	// ------------------------------------------------------------------
	logic                         is_sample_s1;
	logic [vabd_pkg::ACC_W-1:0]   acc_next;
	logic [vabd_pkg::CNT_W-1:0]   cnt_next;
	logic                         group_done;

	always_comb begin
		is_sample_s1 = (kind_s1 == vabd_pkg::REQ_SAMPLE);
		acc_next     = acc_q + vabd_pkg::ACC_W'(sample_s1);
		cnt_next     = cnt_q + vabd_pkg::CNT_W'(1);
		group_done   = (cnt_next == '0)
			|| ({1'b0, cnt_next} >= (vabd_pkg::CNT_W + 1)'(vabd_pkg::SAMPLES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (go1 && is_sample_s1) begin
			if (group_done) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			item_s2.kind <= kind_s1;
			item_s2.show <= show_s1;
			item_s2.temp <= temp_s1;
			item_s2.done <= is_sample_s1 & group_done;
			sum_s2       <= acc_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 to 3: truncated average, sum / SAMPLES by reciprocal.
	// The average never exceeds one full-scale sample.
	// ------------------------------------------------------------------
	localparam int AVG_PROD_W = vabd_pkg::ACC_W + vabd_pkg::RECIP_W;

	logic [AVG_PROD_W-1:0] avg_prod;
	assign avg_prod = AVG_PROD_W'(sum_s2) * AVG_PROD_W'(vabd_pkg::AVG_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			item_s3 <= item_s2;
			avg_s3  <= avg_prod[vabd_pkg::AVG_SHIFT +: vabd_pkg::SAMPLE_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3 to 4: scale to tenths of a volt with rounding by 511/1023.
	// The times-33 is a shift and add; the division is a reciprocal
	// multiply. The result is at most 33.
	// ------------------------------------------------------------------
	localparam int DIV_PROD_W = vabd_pkg::SCALE_W + vabd_pkg::DIV_RECIP_W;

	logic [vabd_pkg::SCALE_W-1:0] scaled;
	logic [DIV_PROD_W-1:0]        div_prod;

	always_comb begin
		scaled = {1'b0, avg_s3, 5'b00000}
			+ vabd_pkg::SCALE_W'(avg_s3)
			+ vabd_pkg::SCALE_W'(vabd_pkg::SCALE_ROUND);
		div_prod = DIV_PROD_W'(scaled) * DIV_PROD_W'(vabd_pkg::DIV_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (free4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			item_s4 <= item_s3;
			volt_s4 <= div_prod[vabd_pkg::DIV_SHIFT +: vabd_pkg::VOLT_W];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: display stage. State written here is seen by every later
	// tick, which keeps the order of transactions as they were accepted.
	// ------------------------------------------------------------------
	vabd_pkg::digit_t digit;

	vabd_digit_mux u_digit_mux (
		.show_temperature (item_s4.show),
		.high_digit       (high_next_q),
		.voltage_digits   (volt_digits_q),
		.temperature      (temp_store_q),
		.digit            (digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_digits_q <= '0;
			temp_store_q  <= '0;
			high_next_q   <= 1'b0;
		end else if (go4) begin
			unique case (item_s4.kind)
				vabd_pkg::REQ_SAMPLE: begin
					if (item_s4.done) begin
						volt_digits_q <= vabd_pkg::to_digits(8'(volt_s4));
					end
				end
				vabd_pkg::REQ_TEMP: begin
					temp_store_q <= item_s4.temp;
				end
				vabd_pkg::REQ_TICK: begin
					high_next_q <= ~high_next_q;
				end
				default: begin
					// Unused request code: nothing changes.
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic res_load;
	assign res_load = go4 & tick_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sel_q   <= digit.sel;
			res_seg_q   <= digit.segments;
			res_point_q <= digit.point;
			res_volt_q  <= volt_digits_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.digit_select  = res_sel_q;
	assign res.segments      = res_seg_q;
	assign res.decimal_point = res_point_q;
	assign res.voltage_bcd   = res_volt_q;

endmodule

FILE: sv/vabd_digit_mux.sv
// ----------------------------------------------------------------------------
// vabd_digit_mux: digit selection and segment decode
// Picks the voltage or temperature nibble for the current digit and decodes it.
// ----------------------------------------------------------------------------
module vabd_digit_mux (
	input  logic                show_temperature,
	input  logic                high_digit,
	input  logic [7:0]          voltage_digits,
	input  logic [7:0]          temperature,
	output vabd_pkg::digit_t    digit
);

	logic [7:0] shown;
	logic [3:0] nib;

	always_comb begin
		if (show_temperature) begin
			shown = vabd_pkg::to_digits(temperature);
		end else begin
			shown = voltage_digits;
		end
		nib = high_digit ? shown[7:4] : shown[3:0];

		digit.sel      = high_digit;
		digit.segments = vabd_pkg::seg7(nib);
		// The point sits after the volts digit, so only in voltage mode.
		digit.point    = high_digit & ~show_temperature;
	end

endmodule
